/* design/ccg_pkg.sv */
package ccg_pkg;

  localparam int MAX_PARAMS  = 64;
  localparam int MAX_ROWS    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int KW   = $clog2(MAX_PARAMS);   // parameter index bits
  localparam int PW   = 7;                    // param_total bits
  localparam int RW   = 11;                   // row_total bits
  localparam int CSW  = 48;                   // column sum width
  localparam int XSW  = 64;                   // cross sum width
  localparam int ESW  = 48;                   // energy sum width

  // configuration register indexes
  localparam logic [1:0] REG_ROW_TOTAL   = 2'd0;
  localparam logic [1:0] REG_PARAM_TOTAL = 2'd1;
  localparam logic [1:0] REG_MEAN_LOSS   = 2'd2;
  localparam logic [1:0] REG_INV_SAMPLES = 2'd3;

  // operation codes
  localparam logic OP_DERIV  = 1'b0;
  localparam logic OP_ENERGY = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic signed [VALUE_WIDTH-1:0] value;
  } queue_entry_t;

  typedef struct packed {
    logic head_valid;
  } queue_status_t;

  typedef struct packed {
    logic                  start;
    logic signed [CSW-1:0] dividend;
    logic [RW-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [CSW-1:0] quotient;
  } div_rsp_t;

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* design/ccg_ram.sv */
module ccg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/ccg_front.sv */
module ccg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic signed [ccg_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                 pop,
  output ccg_pkg::queue_entry_t                head,
  output ccg_pkg::queue_status_t               status
);

  localparam int AW = $clog2(ccg_pkg::QUEUE_DEPTH);

  ccg_pkg::queue_entry_t entries [ccg_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          take;

  assign in_ready = (count != (AW+1)'(ccg_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign take     = pop && (count != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].operation <= operation;
      entries[wr_ptr].value     <= value;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (take) rd_ptr <= rd_ptr + AW'(1);
      if (push && !take) begin
        count <= count + (AW+1)'(1);
      end else if (take && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  assign head              = entries[rd_ptr];
  assign status.head_valid = (count != '0);

endmodule

/* design/ccg_div.sv */
module ccg_div (
  input  logic                clk,
  input  logic                rst,
  input  ccg_pkg::div_req_t   req,
  output ccg_pkg::div_rsp_t   rsp
);

  localparam int N  = ccg_pkg::CSW;
  localparam int CW = $clog2(N);
  localparam int RW = ccg_pkg::RW;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [N-1:0]  quo;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic          neg;
  logic [RW:0]   trial;
  logic          fits;
  logic [N-1:0]  up;

  // one restoring step a cycle
  assign trial = {rem, quo[N-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CW'(N-1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(N-1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[N-1];
      quo <= req.dividend[N-1] ? N'(-req.dividend) : N'(req.dividend);
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? RW'(trial - {1'b0, dvs}) : trial[RW-1:0];
      quo <= {quo[N-2:0], fits};
    end
  end

  // floor for negative dividends
  assign up           = quo + N'(rem != '0);
  assign rsp.done     = done;
  assign rsp.quotient = neg ? $signed(-up) : $signed(quo);

endmodule

/* design/ccg_back.sv */
module ccg_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  ccg_pkg::queue_entry_t      head,
  input  ccg_pkg::queue_status_t     status,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ccg_pkg::KW-1:0]     param_index,
  output logic signed [31:0]         gradient,
  output logic                       last
);

  localparam int KW  = ccg_pkg::KW;
  localparam int PW  = ccg_pkg::PW;
  localparam int RW  = ccg_pkg::RW;
  localparam int CSW = ccg_pkg::CSW;
  localparam int XSW = ccg_pkg::XSW;
  localparam int ESW = ccg_pkg::ESW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EN_MUL = 4'd1;
  localparam logic [3:0] S_EN_ACC = 4'd2;
  localparam logic [3:0] S_DV_MUL = 4'd3;
  localparam logic [3:0] S_DV_ACC = 4'd4;
  localparam logic [3:0] S_EM_RD  = 4'd5;
  localparam logic [3:0] S_EM_LD  = 4'd6;
  localparam logic [3:0] S_EM_DIV = 4'd7;
  localparam logic [3:0] S_EM_MUL = 4'd8;
  localparam logic [3:0] S_EM_OUT = 4'd9;

  // configuration
  logic [RW-1:0]      row_total;
  logic [PW-1:0]      param_total;
  logic signed [31:0] mean_loss;
  logic [30:0]        inv_samples;
  logic [PW-1:0]      eff_p;
  logic [RW-1:0]      eff_r;

  // accumulator state
  logic [3:0]            state;
  logic [ccg_pkg::MAX_PARAMS-1:0] ent_valid;
  logic signed [ESW-1:0] energy_sum;
  logic signed [31:0]    cur_centered;
  logic [RW-1:0]         row_count;
  logic [PW-1:0]         column_count;
  logic signed [31:0]    item_val;
  logic signed [63:0]    prod;
  logic [KW-1:0]         em_k;
  logic [1:0]            mul_step;
  logic signed [CSW-1:0] mean;
  logic signed [XSW-1:0] cross_cur;
  logic signed [63:0]    acc_a;
  logic signed [63:0]    acc_b;

  // memories
  logic           col_we;
  logic [KW-1:0]  rd_addr;
  logic [CSW-1:0] col_rd;
  logic [XSW-1:0] cross_rd;
  logic [CSW-1:0] col_new;
  logic [XSW-1:0] cross_new;

  ccg_pkg::div_req_t div_req;
  ccg_pkg::div_rsp_t div_rsp;

  logic [KW-1:0]         k;
  logic signed [32:0]    diff;
  logic signed [64:0]    en_prod;
  logic signed [63:0]    dv_prod;
  logic signed [63:0]    prod_sh;
  logic signed [31:0]    centered;
  logic signed [CSW-1:0] col_old;
  logic signed [XSW-1:0] cross_old;
  logic [PW:0]           col_inc;
  logic [RW:0]           row_inc;
  logic signed [24:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [57:0]    mul_p;
  logic signed [63:0]    mul_ext;
  logic signed [63:0]    mul_hi;
  logic signed [63:0]    term;
  logic signed [31:0]    f_val;
  logic                  em_last;
  logic                  out_free;

  // clamped counts
  always_comb begin
    if (param_total == '0) begin
      eff_p = PW'(1);
    end else if (param_total > PW'(ccg_pkg::MAX_PARAMS)) begin
      eff_p = PW'(ccg_pkg::MAX_PARAMS);
    end else begin
      eff_p = param_total;
    end
    if (row_total == '0) begin
      eff_r = RW'(1);
    end else if (row_total > RW'(ccg_pkg::MAX_ROWS)) begin
      eff_r = RW'(ccg_pkg::MAX_ROWS);
    end else begin
      eff_r = row_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_total   <= RW'(1);
      param_total <= PW'(1);
      mean_loss   <= '0;
      inv_samples <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        ccg_pkg::REG_ROW_TOTAL:   row_total   <= cfg_data[RW-1:0];
        ccg_pkg::REG_PARAM_TOTAL: param_total <= cfg_data[PW-1:0];
        ccg_pkg::REG_MEAN_LOSS:   mean_loss   <= cfg_data;
        ccg_pkg::REG_INV_SAMPLES: inv_samples <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // datapath
  assign k        = (column_count >= PW'(ccg_pkg::MAX_PARAMS)) ?
                    KW'(ccg_pkg::MAX_PARAMS - 1) : column_count[KW-1:0];
  assign diff     = {item_val[31], item_val} - {mean_loss[31], mean_loss};
  assign en_prod  = diff * $signed({1'b0, inv_samples});
  assign dv_prod  = item_val * cur_centered;
  assign prod_sh  = prod >>> 16;
  assign centered = ccg_pkg::sat32(prod_sh);
  assign col_old  = ent_valid[k] ? $signed(col_rd) : '0;
  assign cross_old = ent_valid[k] ? $signed(cross_rd) : '0;
  assign col_new  = col_old + {{(CSW-32){item_val[31]}}, item_val};
  assign cross_new = cross_old + prod_sh;
  assign col_inc  = {1'b0, column_count} + (PW+1)'(1);
  assign row_inc  = {1'b0, row_count} + (RW+1)'(1);
  assign col_we   = (state == S_DV_ACC);
  assign rd_addr  = (state == S_IDLE || state == S_DV_MUL) ? k : em_k;

  ccg_ram #(.WIDTH(CSW), .DEPTH(ccg_pkg::MAX_PARAMS)) u_col_ram (
    .clk(clk), .wr_en(col_we), .wr_addr(k), .wr_data(col_new),
    .rd_addr(rd_addr), .rd_data(col_rd)
  );

  ccg_ram #(.WIDTH(XSW), .DEPTH(ccg_pkg::MAX_PARAMS)) u_cross_ram (
    .clk(clk), .wr_en(col_we), .wr_addr(k), .wr_data(cross_new),
    .rd_addr(rd_addr), .rd_data(cross_rd)
  );

  // mean times energy sum, split into 24-bit halves of the mean
  always_comb begin
    case (mul_step)
      2'd0: begin mul_a = {1'b0, mean[23:0]}; mul_b = {energy_sum[47], energy_sum[47:16]}; end
      2'd1: begin mul_a = {mean[47], mean[47:24]}; mul_b = {energy_sum[47], energy_sum[47:16]}; end
      2'd2: begin mul_a = {1'b0, mean[23:0]}; mul_b = {17'd0, energy_sum[15:0]}; end
      default: begin mul_a = {mean[47], mean[47:24]}; mul_b = {17'd0, energy_sum[15:0]}; end
    endcase
  end
  assign mul_p   = mul_a * mul_b;
  assign mul_ext = {{6{mul_p[57]}}, mul_p};
  assign mul_hi  = {mul_p[39:0], 24'd0};

  assign term     = acc_a + (acc_b >>> 16);
  assign f_val    = ccg_pkg::sat32(cross_cur - term);
  assign em_last  = ({1'b0, em_k} + PW'(1)) == eff_p;
  assign out_free = !out_valid || out_ready;

  assign div_req.start    = (state == S_EM_LD);
  assign div_req.dividend = ent_valid[em_k] ? $signed(col_rd) : '0;
  assign div_req.divisor  = eff_r;

  ccg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign pop = (state == S_IDLE) && status.head_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ent_valid    <= '0;
      energy_sum   <= '0;
      cur_centered <= '0;
      row_count    <= '0;
      column_count <= '0;
      out_valid    <= 1'b0;
      em_k         <= '0;
      mul_step     <= '0;
    end else begin
      if (state == S_EM_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (status.head_valid) begin
            state <= (head.operation == ccg_pkg::OP_ENERGY) ? S_EN_MUL : S_DV_MUL;
          end
        end
        S_EN_MUL: state <= S_EN_ACC;
        S_EN_ACC: begin
          cur_centered <= centered;
          energy_sum   <= energy_sum + {{(ESW-32){centered[31]}}, centered};
          column_count <= '0;
          state        <= S_IDLE;
        end
        S_DV_MUL: state <= S_DV_ACC;
        S_DV_ACC: begin
          ent_valid[k] <= 1'b1;
          if (col_inc >= {1'b0, eff_p}) begin
            column_count <= '0;
            row_count    <= row_inc[RW-1:0];
            if (row_inc >= {1'b0, eff_r}) begin
              em_k  <= '0;
              state <= S_EM_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            column_count <= col_inc[PW-1:0];
            state        <= S_IDLE;
          end
        end
        S_EM_RD: state <= S_EM_LD;
        S_EM_LD: state <= S_EM_DIV;
        S_EM_DIV: begin
          if (div_rsp.done) begin
            mul_step <= '0;
            state    <= S_EM_MUL;
          end
        end
        S_EM_MUL: begin
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd3) state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_free) begin
            if (em_last) begin
              ent_valid    <= '0;
              energy_sum   <= '0;
              cur_centered <= '0;
              row_count    <= '0;
              column_count <= '0;
              state        <= S_IDLE;
            end else begin
              em_k  <= em_k + KW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) item_val <= head.value;
    if (state == S_EN_MUL) prod <= en_prod[63:0];
    if (state == S_DV_MUL) prod <= dv_prod;
    if (state == S_EM_LD) cross_cur <= ent_valid[em_k] ? $signed(cross_rd) : '0;
    if (state == S_EM_DIV && div_rsp.done) mean <= div_rsp.quotient;
    if (state == S_EM_MUL) begin
      case (mul_step)
        2'd0: acc_a <= mul_ext;
        2'd1: acc_a <= acc_a + mul_hi;
        2'd2: acc_b <= mul_ext;
        default: acc_b <= acc_b + mul_hi;
      endcase
    end
    if (state == S_EM_OUT && out_free) begin
      param_index <= em_k;
      gradient    <= f_val;
      last        <= em_last;
    end
  end

endmodule

/* design/centered_covariance_gradient.sv */
// Centered covariance gradient.
// Input requests (in_valid/in_ready) carry operation and value: an energy
// request (operation 1) opens a sample, followed by param_total derivative
// requests. Inputs pass through a 4-entry queue, so the port keeps taking
// requests while the back end computes or waits on the output.
// The back end multiplies each request, then accumulates an energy one or
// does a read-modify-write of the sum memories for a derivative one. After
// the last derivative of row_total samples (clamped to 1..1024) the block
// emits param_total (clamped to 1..64) result requests (out_valid/out_ready)
// with param_index, gradient and last; each takes a memory read, a load, the
// 48-step bit-serial divider for the column mean, four multiplier passes and
// an output step. The result sits in an output register; if the receiver
// stalls, the emission holds and input requests queue until the queue is
// full. Configuration (cfg_we, cfg_index, cfg_data) is written with no
// wait, only while the block is idle; the user must ensure this, the block
// does not. Synchronous reset restores the register defaults and clears all
// sums, counts and the queue; no result is pending after it.
module centered_covariance_gradient (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         param_index,
  output logic signed [31:0] gradient,
  output logic               last
);

  ccg_pkg::queue_entry_t  head;
  ccg_pkg::queue_status_t status;
  logic                   pop;

  ccg_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .value(value), .pop(pop), .head(head),
    .status(status)
  );

  ccg_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .head(head), .status(status), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .param_index(param_index),
    .gradient(gradient), .last(last)
  );

  // back end only takes from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.head_valid)
    else $error("pop from empty queue");

  // a full queue always presents a head
  a_full_head: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> status.head_valid)
    else $error("full queue without head");

  // no result pending straight after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

/* tb/tb.sv */
module tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [5:0]         index;
    logic signed [31:0] grad;
    logic               tail;
  } grad_entry_t;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = ccg_pkg::REG_ROW_TOTAL;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = ccg_pkg::OP_DERIV;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         param_index;
  logic signed [31:0] gradient;
  logic               last;

  // pending requests and expected gradient entries
  ccg_pkg::queue_entry_t pending_items[$];
  grad_entry_t  expected_grads[$];
  int           mismatches = 0;
  int           cycles = 0;

  // shadow configuration and accumulators
  logic [10:0]        rows_reg;
  logic [6:0]         params_reg;
  logic signed [31:0] mean_reg;
  logic [30:0]        inv_reg;
  longint             col_sum[ccg_pkg::MAX_PARAMS];
  longint             xsum[ccg_pkg::MAX_PARAMS];
  logic signed [47:0] energy_total;
  logic signed [31:0] centred;
  int                 row_cnt;
  int                 col_cnt;

  centered_covariance_gradient i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .param_index(param_index),
    .gradient   (gradient),
    .last       (last)
  );

  always #2 clk = ~clk;

  function automatic logic signed [31:0] clip32(input wide_t x);
    if (x > 128'sd2147483647) return 32'sh7fffffff;
    if (x < -128'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic void clear_sums();
    for (int k = 0; k < ccg_pkg::MAX_PARAMS; k++) begin
      col_sum[k] = 0;
      xsum[k] = 0;
    end
    energy_total = '0;
    centred = '0;
    row_cnt = 0;
    col_cnt = 0;
  endfunction

  // work out the gradient entries an accepted request produces
  function automatic void gradient_step(input logic op, input logic signed [31:0] v);
    int     eff_p;
    int     eff_r;
    int     k;
    wide_t  prod;
    wide_t  term;
    longint mean;
    eff_p = (params_reg == 0) ? 1 :
            (params_reg > ccg_pkg::MAX_PARAMS) ? ccg_pkg::MAX_PARAMS : params_reg;
    eff_r = (rows_reg == 0) ? 1 :
            (rows_reg > ccg_pkg::MAX_ROWS) ? ccg_pkg::MAX_ROWS : rows_reg;
    if (op == ccg_pkg::OP_ENERGY) begin
      prod = (wide_t'(v) - wide_t'(mean_reg)) * wide_t'({1'b0, inv_reg});
      centred = clip32(prod >>> 16);
      energy_total = energy_total + 48'(centred);
      col_cnt = 0;
      return;
    end
    k = (col_cnt >= ccg_pkg::MAX_PARAMS) ? ccg_pkg::MAX_PARAMS - 1 : col_cnt;
    col_sum[k] += longint'(v);
    xsum[k] += (longint'(v) * longint'(centred)) >>> 16;
    col_cnt++;
    if (col_cnt < eff_p) return;
    col_cnt = 0;
    row_cnt++;
    if (row_cnt < eff_r) return;
    for (int j = 0; j < eff_p; j++) begin
      grad_entry_t e;
      mean = col_sum[j] / longint'(eff_r);
      if ((col_sum[j] % longint'(eff_r)) != 0 && col_sum[j] < 0) mean--;
      term = (wide_t'(mean) * wide_t'(energy_total)) >>> 16;
      e.index = j[5:0];
      e.grad  = clip32(wide_t'(xsum[j]) - term);
      e.tail  = (j == eff_p - 1);
      expected_grads.push_back(e);
    end
    clear_sums();
  endfunction

  // driver: bursts of requests separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) gradient_step(operation, value);
      if (in_valid && !in_ready) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        ccg_pkg::queue_entry_t it;
        it = pending_items.pop_front();
        operation <= it.operation;
        value     <= it.value;
        in_valid  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks results, varies the receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d gradient %0d last %0b",
                     param_index, gradient, last);
        end else begin
          grad_entry_t e;
          e = expected_grads.pop_front();
          if (e.index !== param_index || e.grad !== gradient || e.tail !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx %0d grad %0d last %0b, got idx %0d grad %0d last %0b",
                       e.index, e.grad, e.tail, param_index, gradient, last);
          end
        end
      end
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      ccg_pkg::REG_ROW_TOTAL:   rows_reg   = data[10:0];
      ccg_pkg::REG_PARAM_TOTAL: params_reg = data[6:0];
      ccg_pkg::REG_MEAN_LOSS:   mean_reg   = data;
      default:                  inv_reg    = data[30:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int r, input int p, input logic [31:0] m,
                            input logic [31:0] inv);
    cfg_write(ccg_pkg::REG_ROW_TOTAL, 32'(r));
    cfg_write(ccg_pkg::REG_PARAM_TOTAL, 32'(p));
    cfg_write(ccg_pkg::REG_MEAN_LOSS, m);
    cfg_write(ccg_pkg::REG_INV_SAMPLES, inv);
  endtask

  // wait for the block to drain, then let trailing requests settle
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_grads.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_req(input logic op, input logic signed [31:0] v);
    ccg_pkg::queue_entry_t it;
    it.operation = op;
    it.value = v;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
    endcase
  endfunction

  task automatic push_sample(input int p);
    push_req(ccg_pkg::OP_ENERGY, pick_value());
    for (int j = 0; j < p; j++) push_req(ccg_pkg::OP_DERIV, pick_value());
  endtask

  initial begin
    int r;
    int p;
    int n;
    rows_reg = 11'd1;
    params_reg = 7'd1;
    mean_reg = '0;
    inv_reg = 31'd65536;
    clear_sums();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: extremes, missing energy, repeated energy
    push_req(ccg_pkg::OP_ENERGY, 32'sh7fffffff);
    push_req(ccg_pkg::OP_DERIV, 32'sh7fffffff);
    push_req(ccg_pkg::OP_ENERGY, 32'sh80000000);
    push_req(ccg_pkg::OP_DERIV, 32'sh80000000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00010000);
    push_req(ccg_pkg::OP_ENERGY, 32'sh00030000);
    push_req(ccg_pkg::OP_ENERGY, 32'shfffe8000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00020000);
    wait_idle();

    // zero counts act as one; centred energy saturates
    set_config(0, 0, 32'h80000000, 32'h7fffffff);
    push_req(ccg_pkg::OP_ENERGY, 32'sh7fffffff);
    push_req(ccg_pkg::OP_DERIV, 32'sh12345678);
    push_req(ccg_pkg::OP_ENERGY, 32'sh80000000);
    push_req(ccg_pkg::OP_DERIV, 32'sh80000000);
    wait_idle();

    // mid-sample energy, then leave the set unfinished
    set_config(2, 4, 32'h7fffffff, 32'h0);
    push_req(ccg_pkg::OP_ENERGY, 32'sh00050000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00010000);
    push_req(ccg_pkg::OP_DERIV, 32'shffff0000);
    push_req(ccg_pkg::OP_ENERGY, 32'sh00010000);
    push_req(ccg_pkg::OP_DERIV, 32'sh7fffffff);
    push_req(ccg_pkg::OP_DERIV, 32'sh80000000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00000001);
    push_req(ccg_pkg::OP_DERIV, 32'shffffffff);
    wait_idle();
    set_config(2, 4, 32'h00010000, 32'h00008000);
    push_req(ccg_pkg::OP_ENERGY, 32'sh00040000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00020000);
    push_req(ccg_pkg::OP_DERIV, 32'sh00030000);
    push_req(ccg_pkg::OP_DERIV, 32'shfffd0000);
    wait_idle();

    // lowered count completes the open sample and the set
    cfg_write(ccg_pkg::REG_PARAM_TOTAL, 32'd2);
    push_req(ccg_pkg::OP_DERIV, 32'sh00070000);
    wait_idle();

    // widest parameter count, oversize value acts as the maximum
    set_config(1, 127, 32'h0, 32'h00010000);
    push_sample(64);
    wait_idle();

    // oversize row count keeps the set open, a lowered one closes it
    set_config(2047, 1, 32'hffff0000, 32'h00000400);
    for (int j = 0; j < 3; j++) push_sample(1);
    wait_idle();
    cfg_write(ccg_pkg::REG_ROW_TOTAL, 32'd3);
    push_sample(1);
    wait_idle();

    // random phases: mostly well-formed samples, some broken ones
    for (int ph = 0; ph < 4; ph++) begin
      r = $urandom_range(1, 4);
      p = $urandom_range(1, 6);
      set_config(r, p, pick_value(), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
      n = 0;
      while (n < 12) begin
        case ($urandom_range(0, 9))
          7: begin
            push_req(ccg_pkg::OP_DERIV, pick_value());
            n += 1;
          end
          8: begin
            push_req(ccg_pkg::OP_ENERGY, pick_value());
            push_req(ccg_pkg::OP_DERIV, pick_value());
            push_sample(p);
            n += p + 3;
          end
          9: begin
            push_req(ccg_pkg::OP_ENERGY, pick_value());
            push_sample(p);
            n += p + 2;
          end
          default: begin
            push_sample(p);
            n += p + 1;
          end
        endcase
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ccg_pkg.sv
design/ccg_ram.sv
design/ccg_front.sv
design/ccg_div.sv
design/ccg_back.sv
design/centered_covariance_gradient.sv
tb/tb.sv
